[rtl/cdus_pkg.sv]
package cdus_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned EPOCH_W = 32;

	localparam int unsigned DCNT_W  = 16;   // days since 1970, max 47481
	localparam int unsigned TOD_W   = 17;   // seconds into the day, max 86399
	localparam int unsigned YOFF_W  = 7;    // years since 2000, 0..99

	localparam logic [YEAR_W-1:0]  YEAR_FIRST   = 14'd2000;
	localparam logic [YEAR_W-1:0]  YEAR_LAST    = 14'd2099;
	localparam logic [DCNT_W-1:0]  DAYS_TO_2000 = 16'd10957;
	localparam logic [TOD_W-1:0]   SECS_PER_DAY = 17'd86400;
	localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]         SECS_PER_MIN = 6'd60;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [HOUR_W-1:0]  HOUR_MAX = 5'd23;
	localparam logic [MIN_W-1:0]   MIN_MAX  = 6'd59;
	localparam logic [SEC_W-1:0]   SEC_MAX  = 6'd59;

	// day count and time of day handed from the calendar stage to the seconds stage
	typedef struct packed {
		logic              ok;
		logic [DCNT_W-1:0] days;
		logic [TOD_W-1:0]  tod;
	} cdus_days_t;

	// month length in a common year, month numbered 1..12
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo);
		logic [DAY_W-1:0] r;
		case (mo)
			4'd1:    r = 5'd31;
			4'd2:    r = 5'd28;
			4'd3:    r = 5'd31;
			4'd4:    r = 5'd30;
			4'd5:    r = 5'd31;
			4'd6:    r = 5'd30;
			4'd7:    r = 5'd31;
			4'd8:    r = 5'd31;
			4'd9:    r = 5'd30;
			4'd10:   r = 5'd31;
			4'd11:   r = 5'd30;
			4'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// days in the months before this one, common year
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mo);
		logic [8:0] r;
		case (mo)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/civil_date_to_unix_seconds_core.sv]
// Calendar date and time to Unix epoch seconds.
// Pipeline registers from input transaction to result: input, day-count, result.
// Throughput: one transaction per cycle; each stage advances when the one after it
// is empty or moving, so back-pressure only stalls once all three stages are full.
// Reset (arst_n low, asynchronous) empties the pipeline; payload registers are not reset.
module civil_date_to_unix_seconds_core
	import cdus_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	input  logic [HOUR_W-1:0]  hour,
	input  logic [MIN_W-1:0]   minute,
	input  logic [SEC_W-1:0]   second,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic [EPOCH_W-1:0] epoch_seconds
);

	logic               v_s1, v_s2, v_s3;
	logic               adv1, adv2, adv3;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [HOUR_W-1:0]  hour_s1;
	logic [MIN_W-1:0]   minute_s1;
	logic [SEC_W-1:0]   second_s1;
	cdus_days_t         dc_d, dc_s2;
	logic               ok_d;
	logic [EPOCH_W-1:0] epoch_d;
	logic               ok_s3;
	logic [EPOCH_W-1:0] epoch_s3;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			year_s1   <= year;
			month_s1  <= month;
			day_s1    <= day;
			hour_s1   <= hour;
			minute_s1 <= minute;
			second_s1 <= second;
		end
		if (adv2 && v_s1) dc_s2 <= dc_d;
		if (adv3 && v_s2) begin
			ok_s3    <= ok_d;
			epoch_s3 <= epoch_d;
		end
	end

	cdus_days u_days (
		.year   (year_s1),
		.month  (month_s1),
		.day    (day_s1),
		.hour   (hour_s1),
		.minute (minute_s1),
		.second (second_s1),
		.res    (dc_d)
	);

	cdus_secs u_secs (
		.dc    (dc_s2),
		.ok    (ok_d),
		.epoch (epoch_d)
	);

	assign out_valid     = v_s3;
	assign valid_res     = ok_s3;
	assign epoch_seconds = epoch_s3;

endmodule

[rtl/cdus_days.sv]
module cdus_days
	import cdus_pkg::*;
(
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	input  logic [HOUR_W-1:0]  hour,
	input  logic [MIN_W-1:0]   minute,
	input  logic [SEC_W-1:0]   second,
	output cdus_days_t         res
);

	logic              yr_ok, mo_ok, tm_ok, dy_ok, leap;
	logic [DAY_W-1:0]  mlen;
	logic [YEAR_W-1:0] ydiff;
	logic [YOFF_W-1:0] yoff;
	logic [DCNT_W-1:0] ydays, leapdays, mdays;

	always_comb begin
		yr_ok = (year >= YEAR_FIRST) && (year <= YEAR_LAST);
		mo_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
		tm_ok = (hour <= HOUR_MAX) && (minute <= MIN_MAX) && (second <= SEC_MAX);
		// every year in range divisible by 4 is a leap year
		leap  = (year[1:0] == 2'b00);
		mlen  = month_len(month) + DAY_W'((month == MONTH_FEB) && leap);
		dy_ok = (day != '0) && (day <= mlen);

		ydiff    = year - YEAR_FIRST;
		yoff     = ydiff[YOFF_W-1:0];
		ydays    = DCNT_W'(yoff) * DCNT_W'(365);
		// leap days in the whole years since 2000, 2000 itself included
		leapdays = DCNT_W'((YOFF_W+1)'(yoff) + (YOFF_W+1)'(3)) >> 2;
		mdays    = DCNT_W'(days_before(month))
		         + DCNT_W'((month > MONTH_FEB) && leap)
		         + DCNT_W'(day) - DCNT_W'(1);

		res.ok   = yr_ok && mo_ok && tm_ok && dy_ok;
		res.days = DAYS_TO_2000 + ydays + leapdays + mdays;
		res.tod  = TOD_W'(hour) * TOD_W'(SECS_PER_HOUR)
		         + TOD_W'(minute) * TOD_W'(SECS_PER_MIN)
		         + TOD_W'(second);
	end

endmodule

[rtl/cdus_secs.sv]
module cdus_secs
	import cdus_pkg::*;
(
	input  cdus_days_t         dc,
	output logic               ok,
	output logic [EPOCH_W-1:0] epoch
);

	logic [DCNT_W+TOD_W-1:0] full;

	always_comb begin
		full  = (DCNT_W+TOD_W)'(dc.days) * (DCNT_W+TOD_W)'(SECS_PER_DAY)
		      + (DCNT_W+TOD_W)'(dc.tod);
		ok    = dc.ok;
		epoch = dc.ok ? full[EPOCH_W-1:0] : '0;
	end

endmodule

[dv/tb_civil_date_to_unix_seconds_core.sv]
`timescale 1ns / 100ps

module tb_civil_date_to_unix_seconds_core;
	import cdus_pkg::*;

	localparam int unsigned N_RANDOM    = 1800;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 8;

	localparam int unsigned MDAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} date_t;

	typedef struct packed {
		logic               ok;
		logic [EPOCH_W-1:0] secs;
	} epoch_t;

	typedef struct packed {
		date_t  d;
		logic   typed;   // expectation given in the row, else predicted
		epoch_t want;
	} date_case_t;

	localparam date_case_t DATE_CASES [23] = '{
		'{'{14'd2000,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, '{1'b1, 32'd946684800}},
		'{'{14'd2099,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1, '{1'b1, 32'd4102444799}},
		'{'{14'd1999,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1, '{1'b0, 32'd0}},
		'{'{14'd2100,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd0,     4'd0,  5'd0,  5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b1, '{1'b0, 32'd0}},
		'{'{14'd2000,  4'd2,  5'd29, 5'd12, 6'd30, 6'd30}, 1'b0, '{1'b0, 32'd0}},
		'{'{14'd2001,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2001,  4'd2,  5'd28, 5'd23, 6'd59, 6'd59}, 1'b0, '{1'b0, 32'd0}},
		'{'{14'd2004,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, '{1'b0, 32'd0}},
		'{'{14'd2096,  4'd2,  5'd29, 5'd6,  6'd7,  6'd8},  1'b0, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd0,  5'd10, 5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd13, 5'd10, 5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd4,  5'd31, 5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd4,  5'd0,  5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd6,  5'd15, 5'd24, 6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd6,  5'd15, 5'd0,  6'd60, 6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd6,  5'd15, 5'd0,  6'd0,  6'd60}, 1'b1, '{1'b0, 32'd0}},
		'{'{14'd2050,  4'd7,  5'd31, 5'd0,  6'd0,  6'd0},  1'b0, '{1'b0, 32'd0}},
		'{'{14'd2023,  4'd11, 5'd30, 5'd17, 6'd45, 6'd9},  1'b0, '{1'b0, 32'd0}},
		'{'{14'd2099,  4'd2,  5'd28, 5'd1,  6'd2,  6'd3},  1'b0, '{1'b0, 32'd0}},
		'{'{14'd2099,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}},
		'{'{14'd8191,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, '{1'b0, 32'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [DAY_W-1:0]   day = '0;
	logic [HOUR_W-1:0]  hour = '0;
	logic [MIN_W-1:0]   minute = '0;
	logic [SEC_W-1:0]   second = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               valid_res;
	logic [EPOCH_W-1:0] epoch_seconds;

	epoch_t      pending_epochs [$];
	int unsigned tx_idle_pct = 24;
	int unsigned rx_idle_pct = 24;
	int unsigned cycle_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned good_dates = 0;
	int unsigned bad_dates = 0;
	int unsigned results_seen = 0;

	civil_date_to_unix_seconds_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.epoch_seconds (epoch_seconds)
	);

	always #6 clk = ~clk;

	function automatic epoch_t expected_epoch(date_t d);
		epoch_t           r;
		logic             leap;
		int unsigned      mlen;
		int unsigned      yoff;
		longint unsigned  ndays;
		r.ok = 1'b0;
		r.secs = '0;
		if (d.year < YEAR_FIRST || d.year > YEAR_LAST || d.month < MONTH_JAN ||
		    d.month > MONTH_DEC || d.hour > HOUR_MAX || d.minute > MIN_MAX ||
		    d.second > SEC_MAX)
			return r;
		// every 4th year is leap inside 2000..2099
		leap = (d.year[1:0] == 2'b00);
		mlen = MDAYS[d.month - 1] + ((d.month == MONTH_FEB && leap) ? 1 : 0);
		if (d.day == 0 || d.day > mlen)
			return r;
		yoff = d.year - YEAR_FIRST;
		ndays = DAYS_TO_2000 + yoff * 365 + (yoff + 3) / 4;
		for (int m = 1; m < d.month; m++)
			ndays += MDAYS[m - 1];
		if (d.month > MONTH_FEB && leap)
			ndays++;
		ndays += d.day - 1;
		r.ok = 1'b1;
		r.secs = EPOCH_W'(ndays * SECS_PER_DAY + d.hour * SECS_PER_HOUR +
		                  d.minute * SECS_PER_MIN + d.second);
		return r;
	endfunction

	// mostly legal dates, some with one field pushed out of range, some raw noise
	function automatic date_t random_date();
		date_t       d;
		int unsigned mlen;
		int unsigned pick;
		pick = $urandom_range(99);
		d.year = YEAR_W'(2000 + $urandom_range(99));
		d.month = MONTH_W'($urandom_range(12, 1));
		mlen = MDAYS[d.month - 1] + ((d.month == MONTH_FEB && d.year[1:0] == 2'b00) ? 1 : 0);
		d.day = DAY_W'((pick < 15) ? mlen : $urandom_range(mlen, 1));
		d.hour = HOUR_W'($urandom_range(23));
		d.minute = MIN_W'($urandom_range(59));
		d.second = SEC_W'($urandom_range(59));
		if (pick >= 90) begin
			d = date_t'({$urandom, 8'($urandom)});
		end else if (pick >= 72) begin
			case ($urandom_range(5))
				0: d.year = YEAR_W'($urandom_range(1) ? $urandom_range(1999) :
				                    $urandom_range(16383, 2100));
				1: d.month = MONTH_W'($urandom_range(1) ? 0 : $urandom_range(15, 13));
				2: d.day = DAY_W'((mlen == 31 || $urandom_range(1)) ? 0 :
				                  $urandom_range(31, mlen + 1));
				3: d.hour = HOUR_W'($urandom_range(31, 24));
				4: d.minute = MIN_W'($urandom_range(63, 60));
				default: d.second = SEC_W'($urandom_range(63, 60));
			endcase
		end
		return d;
	endfunction

	// called and returns on a falling edge
	task automatic drive_date(input date_t d, input epoch_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		year     <= d.year;
		month    <= d.month;
		day      <= d.day;
		hour     <= d.hour;
		minute   <= d.minute;
		second   <= d.second;
		do @(posedge clk); while (!in_ready);
		pending_epochs.push_back(want);
		if (want.ok)
			good_dates++;
		else
			bad_dates++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_epochs.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin : check_results
		epoch_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_epochs.size() == 0) begin
				$error("result transaction with nothing expected: valid_res=%0b epoch_seconds=%0d",
				       valid_res, epoch_seconds);
				mismatch_cnt++;
			end else begin
				want = pending_epochs.pop_front();
				if (valid_res !== want.ok) begin
					$error("valid_res mismatch: expected %0b, got %0b", want.ok, valid_res);
					mismatch_cnt++;
				end
				if (epoch_seconds !== want.secs) begin
					$error("epoch_seconds mismatch: expected %0d, got %0d",
					       want.secs, epoch_seconds);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_cnt, pending_epochs.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		date_t  d;
		epoch_t want;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DATE_CASES[i]) begin
			want = DATE_CASES[i].typed ? DATE_CASES[i].want : expected_epoch(DATE_CASES[i].d);
			drive_date(DATE_CASES[i].d, want);
		end
		wait_drained();

		for (int n = 0; n < N_RANDOM; n++) begin
			// back-to-back stretch with no stalls on either side
			if (n == 600) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (n == 1000) begin
				tx_idle_pct = 24;
				rx_idle_pct = 24;
			end
			if (n == 1300)
				wait_drained();
			d = random_date();
			drive_date(d, expected_epoch(d));
		end
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d dates: %0d in range, %0d rejected; %0d results checked in %0d cycles.",
		         good_dates + bad_dates, good_dates, bad_dates, results_seen, cycle_cnt);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
